// File: rtl/eiph_pkg.sv
// Shared types and constants for the Ethernet/IP header parser.
// Used by every module of the block; depends on nothing else.

package eiph_pkg;

    // EtherType codes.
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    // Protocol and next-header codes.
    localparam logic [7:0] NH_TCP   = 8'd6;
    localparam logic [7:0] NH_UDP   = 8'd17;
    localparam logic [7:0] NH_ICMP6 = 8'd58;
    localparam logic [7:0] NH_NONE  = 8'd59;

    // Layer-3 kind codes reported with each verdict.
    localparam logic [1:0] L3_OTHER = 2'd0;
    localparam logic [1:0] L3_IPV4  = 2'd1;
    localparam logic [1:0] L3_IPV6  = 2'd2;

    // Frame geometry.
    localparam logic [16:0] MAX_FRAME_BYTES = 17'd65535;
    localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
    localparam logic [16:0] ETH_HDR_BYTES   = 17'd14;
    localparam logic [16:0] ETYPE_HI_POS    = 17'd12;
    localparam logic [16:0] ETYPE_LO_POS    = 17'd13;
    localparam logic [16:0] IP_VIH_POS      = 17'd0;
    localparam logic [16:0] IPV4_PROTO_POS  = 17'd9;
    localparam logic [16:0] IPV6_NH_POS     = 17'd6;
    localparam logic [16:0] IPV6_CHAIN_POS  = 17'd7;
    localparam logic [15:0] IPV6_HDR_BYTES  = 16'd40;
    localparam logic [15:0] IPV4_HDR_MIN    = 16'd20;
    localparam logic [15:0] TCP_HDR_MIN     = 16'd20;
    localparam logic [15:0] UDP_HDR_MIN     = 16'd8;
    localparam logic [3:0]  IPV4_VERSION    = 4'd4;
    localparam logic [3:0]  IPV6_VERSION    = 4'd6;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [8:0]  TCP_FLAG_MASK   = 9'h1FF;

    // Register map.
    localparam logic       REG_IDX_MAX_EXT = 1'b0;
    localparam logic [3:0] MAX_EXT_RESET   = 4'd10;

    // Transport words: ports, UDP length, TCP offset/flags word.
    typedef logic [3:0][15:0] word4_t;

    // Per-frame parse state.
    typedef struct packed {
        logic [16:0] cnt;
        logic [15:0] ether;
        logic [7:0]  vih;
        logic [7:0]  nh;
        logic [15:0] neo;
        logic [3:0]  hop;
        logic        stopped;
        logic [7:0]  elb;
        word4_t      words;
    } track_state_t;

    localparam track_state_t TRACK_CLEAR = '{
        cnt:     17'd0,
        ether:   16'd0,
        vih:     8'd0,
        nh:      8'd0,
        neo:     IPV6_HDR_BYTES,
        hop:     4'd0,
        stopped: 1'b0,
        elb:     8'd0,
        words:   '0
    };

    // One verdict.
    typedef struct packed {
        logic        packet_ok;
        logic [15:0] ether_type;
        logic [1:0]  l3_kind;
        logic [7:0]  l4_protocol;
        logic [3:0]  ext_headers_skipped;
        logic        l4_fields_valid;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [8:0]  tcp_flag_bits;
    } result_t;

endpackage

// File: rtl/eiph_track.sv
// Per-byte frame tracker: byte count, EtherType, IP header fields,
// IPv6 extension chain walk and transport word capture. Uses eiph_pkg.

module eiph_track (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 clear,
    input  logic [3:0]           max_ext,
    output eiph_pkg::track_state_t st
);
    import eiph_pkg::*;

    track_state_t st_reg;
    track_state_t st_next;
    track_state_t cur;
    logic [16:0]  q;
    logic [8:0]   len_plus1;
    logic         chain_end;

    // Store one transport byte if it falls on a port, length or flags position.
    function automatic word4_t capture(input word4_t words, input logic [16:0] pos,
                                       input logic [15:0] off, input logic [7:0] b);
        word4_t      res;
        logic [16:0] d;
        logic [1:0]  w;
        res = words;
        d   = pos - {1'b0, off};
        w   = (d >= 17'd12) ? 2'd3 : d[2:1];
        if (pos >= {1'b0, off} && (d < 17'd6 || d == 17'd12 || d == 17'd13))
        begin
            if (!d[0])
            begin
                res[w][15:8] = b;
            end
            else
            begin
                res[w][7:0] = b;
            end
        end
        return res;
    endfunction

    // Next state for one accepted byte; a finished frame starts from clear.
    always_comb
    begin
        cur       = clear ? TRACK_CLEAR : st_reg;
        st_next   = cur;
        q         = cur.cnt - ETH_HDR_BYTES;
        len_plus1 = {1'b0, data_byte} + 9'd1;
        chain_end = (cur.nh == NH_TCP) || (cur.nh == NH_UDP) ||
                    (cur.nh == NH_ICMP6) || (cur.nh == NH_NONE);

        if (cur.cnt == ETYPE_HI_POS)
        begin
            st_next.ether = {data_byte, 8'h00};
        end
        else if (cur.cnt == ETYPE_LO_POS)
        begin
            st_next.ether = cur.ether | {8'h00, data_byte};
        end
        else if (cur.cnt >= ETH_HDR_BYTES)
        begin
            if (cur.ether == ETH_IPV4)
            begin
                if (q == IP_VIH_POS)
                begin
                    st_next.vih = data_byte;
                end
                else
                begin
                    if (q == IPV4_PROTO_POS)
                    begin
                        st_next.nh = data_byte;
                    end
                    st_next.words = capture(cur.words, q, {10'd0, cur.vih[3:0], 2'b00},
                                            data_byte);
                end
            end
            else if (cur.ether == ETH_IPV6)
            begin
                if (q == IP_VIH_POS)
                begin
                    st_next.vih = data_byte;
                end
                else if (q == IPV6_NH_POS)
                begin
                    st_next.nh = data_byte;
                end
                else if (q >= IPV6_CHAIN_POS)
                begin
                    // The walk stops at a final header or at the hop limit.
                    if (!cur.stopped && !(cur.hop >= max_ext || chain_end))
                    begin
                        if (q == {1'b0, cur.neo})
                        begin
                            st_next.elb = data_byte;
                        end
                        else if (q == {1'b0, cur.neo} + 17'd1)
                        begin
                            st_next.neo = cur.neo + {4'b0000, len_plus1, 3'b000};
                            st_next.nh  = cur.elb;
                            st_next.hop = cur.hop + 4'd1;
                        end
                    end
                    else
                    begin
                        st_next.stopped = 1'b1;
                        st_next.words   = capture(cur.words, q, cur.neo, data_byte);
                    end
                end
            end
        end

        if (cur.cnt != COUNT_MAX)
        begin
            st_next.cnt = cur.cnt + 17'd1;
        end
    end

    // State register; cleared once a frame's verdict has been taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= TRACK_CLEAR;
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
        else if (clear)
        begin
            st_reg <= TRACK_CLEAR;
        end
    end

    assign st = st_reg;

endmodule

// File: rtl/eiph_judge.sv
// Verdict logic: turns the tracker state after a frame's last byte into
// one result. Uses eiph_pkg.

module eiph_judge (
    input  eiph_pkg::track_state_t st,
    input  logic [3:0]             max_ext,
    output eiph_pkg::result_t      res
);
    import eiph_pkg::*;

    typedef struct packed {
        logic        pass;
        logic        valid;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [8:0]  flags;
    } l4_t;

    logic [15:0] r;
    logic [5:0]  t;
    logic        dispatch;
    l4_t         l4;

    // TCP or UDP header check over tl transport bytes.
    function automatic l4_t l4_eval(input logic [7:0] proto, input logic [15:0] tl,
                                    input word4_t words);
        l4_t        o;
        logic [5:0] hl;
        o  = '0;
        hl = {words[3][15:12], 2'b00};
        o.pass = 1'b1;
        if (proto == NH_TCP)
        begin
            if (tl < TCP_HDR_MIN || {10'd0, hl} < TCP_HDR_MIN || tl < {10'd0, hl})
            begin
                o.pass = 1'b0;
            end
            else
            begin
                o.valid = 1'b1;
                o.sp    = words[0];
                o.dp    = words[1];
                o.flags = words[3][8:0] & TCP_FLAG_MASK;
            end
        end
        else if (proto == NH_UDP)
        begin
            if (tl < UDP_HDR_MIN || words[2] < UDP_HDR_MIN)
            begin
                o.pass = 1'b0;
            end
            else
            begin
                o.valid = 1'b1;
                o.sp    = words[0];
                o.dp    = words[1];
            end
        end
        return o;
    endfunction

    always_comb
    begin
        res      = '0;
        l4       = '0;
        dispatch = 1'b0;
        r        = 16'(st.cnt - ETH_HDR_BYTES);
        t        = {st.vih[3:0], 2'b00};

        // Runts and over-long frames fail with every field zero.
        if (st.cnt >= ETH_HDR_BYTES && st.cnt <= MAX_FRAME_BYTES)
        begin
            res.packet_ok  = 1'b1;
            res.ether_type = st.ether;
            if (st.ether == ETH_IPV4)
            begin
                res.l3_kind = L3_IPV4;
                if (r < IPV4_HDR_MIN || st.vih[7:4] != IPV4_VERSION || st.vih[3:0] < IHL_MIN)
                begin
                    res.packet_ok = 1'b0;
                end
                else
                begin
                    res.l4_protocol = st.nh;
                    // The transport check only decides which fields are shown.
                    if ((st.nh == NH_TCP || st.nh == NH_UDP) && r > {10'd0, t})
                    begin
                        l4 = l4_eval(st.nh, r - {10'd0, t}, st.words);
                        if (l4.pass)
                        begin
                            res.l4_fields_valid = l4.valid;
                            res.source_port     = l4.sp;
                            res.dest_port       = l4.dp;
                            res.tcp_flag_bits   = l4.flags;
                        end
                    end
                end
            end
            else if (st.ether == ETH_IPV6)
            begin
                res.l3_kind = L3_IPV6;
                if (r < IPV6_HDR_BYTES || st.vih[7:4] != IPV6_VERSION)
                begin
                    res.packet_ok = 1'b0;
                end
                else
                begin
                    res.l4_protocol         = st.nh;
                    res.ext_headers_skipped = st.hop;
                    if (st.hop < max_ext)
                    begin
                        if (st.neo >= r)
                        begin
                            res.packet_ok = 1'b0;
                        end
                        else if (st.nh == NH_TCP || st.nh == NH_UDP || st.nh == NH_ICMP6)
                        begin
                            dispatch = 1'b1;
                        end
                        else if (st.nh != NH_NONE)
                        begin
                            res.packet_ok = 1'b0;
                        end
                    end
                    else
                    begin
                        dispatch = 1'b1;
                    end

                    if (dispatch)
                    begin
                        if (r <= st.neo)
                        begin
                            res.packet_ok = 1'b0;
                        end
                        else
                        begin
                            l4 = l4_eval(st.nh, r - st.neo, st.words);
                            if (!l4.pass)
                            begin
                                res.packet_ok = 1'b0;
                            end
                            else
                            begin
                                res.l4_fields_valid = l4.valid;
                                res.source_port     = l4.sp;
                                res.dest_port       = l4.dp;
                                res.tcp_flag_bits   = l4.flags;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// File: rtl/ethernet_ip_header_parser.sv
// Top level of the Ethernet/IPv4/IPv6 header parser: configuration port,
// byte channel, verdict queue. Uses eiph_pkg, eiph_track and eiph_judge.

// The parser takes one frame byte per clock cycle on the data channel while
// data_stall is low, starting at the destination MAC, and gives one verdict
// beat per frame on the result channel. Each byte updates the registered
// frame state; the verdict is formed from that state on the cycle after the
// last byte is taken and is then written into the queue behind result_valid.
// Up to three verdicts are held in that small queue while result_stall is
// high; data_stall rises only when the queue and the verdict in flight fill
// those three places, so back-to-back frames of any length stream at one byte
// per cycle while result_stall stays low. The max_ext_headers register sits
// at byte address 0 and resets to ten; write it only between frames.

module ethernet_ip_header_parser (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        packet_ok,
    output logic [15:0] ether_type,
    output logic [1:0]  l3_kind,
    output logic [7:0]  l4_protocol,
    output logic [3:0]  ext_headers_skipped,
    output logic        l4_fields_valid,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [8:0]  tcp_flag_bits
);
    import eiph_pkg::*;

    localparam int RQ_DEPTH = 3;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    logic [3:0]          max_ext_reg;
    logic                pend_reg;
    logic                data_accept;
    logic                push;
    logic                pop;
    track_state_t        st;
    result_t             verdict;
    result_t             rq_reg [RQ_DEPTH];
    result_t             head;
    logic [RQ_PTR_W-1:0] wptr_reg;
    logic [RQ_PTR_W-1:0] rptr_reg;
    logic [RQ_CNT_W-1:0] count_reg;
    logic [RQ_CNT_W-1:0] count_next;

    // Configuration register.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ext_reg <= MAX_EXT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_IDX_MAX_EXT)
        begin
            max_ext_reg <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_MAX_EXT) ? {28'd0, max_ext_reg} : 32'd0;

    // Byte channel: stall only when no room is left for another verdict.
    assign data_stall  = ({1'b0, count_reg} + {{RQ_CNT_W{1'b0}}, pend_reg}) >=
                         (RQ_CNT_W + 1)'(RQ_DEPTH);
    assign data_accept = data_valid && !data_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= data_accept && last_byte;
        end
    end

    // Frame tracker and verdict logic.
    eiph_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (data_accept),
        .data_byte (data_byte),
        .clear     (pend_reg),
        .max_ext   (max_ext_reg),
        .st        (st)
    );

    eiph_judge u_judge (
        .st      (st),
        .max_ext (max_ext_reg),
        .res     (verdict)
    );

    // Verdict queue.
    assign push = pend_reg;
    assign pop  = result_valid && !result_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + RQ_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - RQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= (wptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 :
                            wptr_reg + RQ_PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 :
                            rptr_reg + RQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rq_reg[wptr_reg] <= verdict;
        end
    end

    // Result channel driven from the head of the queue.
    assign head                = rq_reg[rptr_reg];
    assign result_valid        = (count_reg != '0);
    assign packet_ok           = head.packet_ok;
    assign ether_type          = head.ether_type;
    assign l3_kind             = head.l3_kind;
    assign l4_protocol         = head.l4_protocol;
    assign ext_headers_skipped = head.ext_headers_skipped;
    assign l4_fields_valid     = head.l4_fields_valid;
    assign source_port         = head.source_port;
    assign dest_port           = head.dest_port;
    assign tcp_flag_bits       = head.tcp_flag_bits;

endmodule

// File: rtl/eiph_checker.sv
// Port-level checks for the header parser, bound to the top level.
// Uses eiph_pkg and watches ethernet_ip_header_parser's ports only.

module eiph_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        data_valid,
    input logic        data_stall,
    input logic [7:0]  data_byte,
    input logic        last_byte,
    input logic        result_valid,
    input logic        result_stall,
    input logic        packet_ok,
    input logic [15:0] ether_type,
    input logic [1:0]  l3_kind,
    input logic [7:0]  l4_protocol,
    input logic [3:0]  ext_headers_skipped,
    input logic        l4_fields_valid,
    input logic [15:0] source_port,
    input logic [15:0] dest_port,
    input logic [8:0]  tcp_flag_bits
);
    import eiph_pkg::*;

    // A stalled result beat stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload, apart from ext_headers_skipped and l4_fields_valid.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(packet_ok) && $stable(ether_type) &&
        $stable(l3_kind) && $stable(l4_protocol) && $stable(source_port) &&
        $stable(dest_port) && $stable(tcp_flag_bits))
        else $error("result payload changed while stalled");

    // Ports and flags are shown only with a passed transport check.
    a_ports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !l4_fields_valid |->
        source_port == 16'd0 && dest_port == 16'd0 && tcp_flag_bits == 9'd0)
        else $error("transport fields shown without a passed check");

    // Flag bits come only from a TCP header.
    a_flags_tcp: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && tcp_flag_bits != 9'd0 |-> l4_fields_valid && l4_protocol == NH_TCP)
        else $error("TCP flags shown for a non-TCP verdict");

    // Extension headers are counted only for IPv6.
    a_hops_v6: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && l3_kind != L3_IPV6 |-> ext_headers_skipped == 4'd0)
        else $error("extension header count on a non-IPv6 verdict");

endmodule

bind ethernet_ip_header_parser eiph_checker u_eiph_checker (.*);
